// File: rtl/tmcw_pkg.sv
// Shared types and constants for the text-mode console writer.
`timescale 1ns / 1ps
`default_nettype none

package tmcw_pkg;

    // Operation codes carried in s_tuser
    localparam logic [2:0] MODE_PRINT      = 3'd0;
    localparam logic [2:0] MODE_SET_CURSOR = 3'd1;
    localparam logic [2:0] MODE_CLEAR      = 3'd2;
    localparam logic [2:0] MODE_READ       = 3'd3;
    localparam logic [2:0] MODE_WRITE      = 3'd4;

    // Character codes and console constants
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [3:0] TAB_STOP   = 4'd8;
    localparam logic [7:0] ATTR_RESET = 8'h07;

    // One cell: attribute in the high byte, character in the low byte
    localparam int CELL_W = 16;

    // Field layout of the result item in m_tdata
    localparam int OUT_COL_LSB  = 0;
    localparam int OUT_ROW_LSB  = 7;
    localparam int OUT_CHAR_LSB = 12;
    localparam int OUT_ATTR_LSB = 20;
    localparam int OUT_SCR_BIT  = 28;
    localparam int OUT_W        = 32;
    localparam int IN_W         = 24;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_ACCESS,
        ST_READ_WAIT,
        ST_COPY,
        ST_COPY_END,
        ST_FILL,
        ST_CLEAR,
        ST_DONE
    } tmcw_state_t;

endpackage : tmcw_pkg

`default_nettype wire

// File: rtl/text_mode_console_writer.sv
// Text console: cursor, print/scroll sequencer and screen cell store.
//
// Usage:
//   s_ channel carries one command item: s_tuser is the mode, s_tdata holds
//   char_code, column and row. m_ channel returns one result item per command
//   with the cursor position, read-back cell and a scroll flag. cfg_ sets the
//   attribute byte used for every character written; it is always ready.
// Sequencing:
//   One command at a time. Print without scroll and unused modes go through
//   ST_EXEC and ST_DONE, set cursor and positioned write also ST_ACCESS, a cell
//   read also ST_ACCESS and ST_READ_WAIT; s_tready comes back in the cycle the
//   result appears. A print that scrolls adds a cell sweep that copies one cell
//   per cycle through the single memory port pair, then fills the bottom row
//   one cell per cycle. Clear screen adds a sweep over every cell.
// Reset:
//   aresetn (synchronous, active low) resets cursor and attribute (7), then a
//   clearing pass zeroes every cell; s_tready stays low during it.
// Stall:
//   The result sits in an output register; the next command is accepted
//   while it waits, but its own result is held back until the register frees.
`timescale 1ns / 1ps
`default_nettype none

module text_mode_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Command items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // char_code[7:0], column[14:8], row[19:15]
    input  wire logic [2:0]  s_tuser,   // mode[2:0]
    // Result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // cursor_column[6:0], cursor_row[11:7],
                                        // read_char[19:12], read_attr[27:20],
                                        // scrolled[28]
    // Attribute register write
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data
);
    import tmcw_pkg::*;

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int OFF_W  = $clog2(CELLS + COLUMNS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);

    localparam logic [ADDR_W-1:0] LAST_CELL   = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] BOTTOM_ROW  = ADDR_W'(CELLS - COLUMNS);
    localparam logic [ADDR_W-1:0] ROW_STRIDE  = ADDR_W'(COLUMNS);
    localparam logic [COL_W:0]    COL_LIMIT   = (COL_W+1)'(COLUMNS);
    localparam logic [COL_W-1:0]  COL_MAX     = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  ROW_MAX     = ROW_W'(ROWS - 1);

    tmcw_state_t state_reg, state_next;

    logic [ADDR_W-1:0] sweep_reg, sweep_next;
    logic [ADDR_W-1:0] off_reg, off_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [7:0]        attr_reg;

    logic [2:0]        mode_reg, mode_next;
    logic [7:0]        char_reg, char_next;
    logic [6:0]        in_col_reg, in_col_next;
    logic [4:0]        in_row_reg, in_row_next;

    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic [COL_W-1:0]  sat_col_reg, sat_col_next;
    logic [ROW_W-1:0]  sat_row_reg, sat_row_next;
    logic              inside_reg, inside_next;

    logic              pend_reg, pend_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;

    logic [7:0]        res_char_reg, res_char_next;
    logic [7:0]        res_attr_reg, res_attr_next;
    logic              res_scr_reg, res_scr_next;

    logic              m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]  m_tdata_reg, m_tdata_next;

    // Memory port signals
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [CELL_W-1:0]     wr_data;
    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;
    logic [CELL_W-1:0]     rd_data;

    // Print arithmetic
    logic [OFF_W-1:0]  off_ext;
    logic [OFF_W-1:0]  pr_off;
    logic [COL_W-1:0]  pr_col;
    logic [ROW_W-1:0]  pr_row;
    logic [3:0]        pr_step;
    logic [COL_W:0]    col_sum;
    logic              pr_scroll;
    logic              col_ok, row_ok;
    logic [COL_W-1:0]  sat_col;
    logic [ROW_W-1:0]  sat_row;

    tmcw_cell_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_cell_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign cfg_ready = 1'b1;

    // Attribute register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attr_reg <= ATTR_RESET;
        end else if (cfg_valid) begin
            attr_reg <= cfg_data;
        end
    end

    // Cursor advance for print: newline, tab or ordinary character
    always_comb begin
        off_ext = OFF_W'(off_reg);
        pr_step = (char_reg == CH_TAB) ? (TAB_STOP - {1'b0, off_reg[2:0]}) : 4'd1;
        col_sum = {1'b0, col_reg} + (COL_W+1)'(pr_step);
        if (char_reg == CH_NEWLINE) begin
            pr_off = off_ext + OFF_W'(COLUMNS) - OFF_W'(col_reg);
            pr_col = '0;
            pr_row = row_reg + ROW_W'(1);
        end else begin
            pr_off = off_ext + OFF_W'(pr_step);
            if (col_sum >= COL_LIMIT) begin
                pr_col = COL_W'(col_sum - COL_LIMIT);
                pr_row = row_reg + ROW_W'(1);
            end else begin
                pr_col = col_sum[COL_W-1:0];
                pr_row = row_reg;
            end
        end
        pr_scroll = (pr_off >= OFF_W'(CELLS));
    end

    // Position saturation for set cursor; also the cell address for read/write
    always_comb begin
        col_ok  = (9'(in_col_reg) < 9'(COLUMNS));
        row_ok  = (8'(in_row_reg) < 8'(ROWS));
        sat_col = col_ok ? COL_W'(in_col_reg) : COL_MAX;
        sat_row = row_ok ? ROW_W'(in_row_reg) : ROW_MAX;
    end

    // Sequencer registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            sweep_reg    <= '0;
            off_reg      <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            sweep_reg    <= sweep_next;
            off_reg      <= off_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        mode_reg      <= mode_next;
        char_reg      <= char_next;
        in_col_reg    <= in_col_next;
        in_row_reg    <= in_row_next;
        pos_reg       <= pos_next;
        sat_col_reg   <= sat_col_next;
        sat_row_reg   <= sat_row_next;
        inside_reg    <= inside_next;
        pend_addr_reg <= pend_addr_next;
        res_char_reg  <= res_char_next;
        res_attr_reg  <= res_attr_next;
        res_scr_reg   <= res_scr_next;
        m_tdata_reg   <= m_tdata_next;
    end

    // Next state, memory port control and result assembly
    always_comb begin
        state_next     = state_reg;
        sweep_next     = sweep_reg;
        off_next       = off_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        mode_next      = mode_reg;
        char_next      = char_reg;
        in_col_next    = in_col_reg;
        in_row_next    = in_row_reg;
        pos_next       = pos_reg;
        sat_col_next   = sat_col_reg;
        sat_row_next   = sat_row_reg;
        inside_next    = inside_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        res_char_next  = res_char_reg;
        res_attr_next  = res_attr_reg;
        res_scr_next   = res_scr_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        wr_en          = 1'b0;
        wr_addr        = sweep_reg;
        wr_data        = {attr_reg, CH_SPACE};
        rd_en          = 1'b0;
        rd_addr        = sweep_reg;

        case (state_reg)
            // Clearing pass after reset: every cell to zero
            ST_INIT: begin
                wr_en   = 1'b1;
                wr_data = '0;
                if (sweep_reg == LAST_CELL) begin
                    state_next = ST_IDLE;
                end else begin
                    sweep_next = sweep_reg + ADDR_W'(1);
                end
            end

            ST_IDLE: begin
                if (s_tvalid) begin
                    mode_next     = s_tuser;
                    char_next     = s_tdata[7:0];
                    in_col_next   = s_tdata[14:8];
                    in_row_next   = s_tdata[19:15];
                    res_char_next = '0;
                    res_attr_next = '0;
                    res_scr_next  = 1'b0;
                    state_next    = ST_EXEC;
                end
            end

            ST_EXEC: begin
                case (mode_reg)
                    MODE_PRINT: begin
                        // ordinary character goes in at the cursor
                        if (char_reg != CH_NEWLINE && char_reg != CH_TAB) begin
                            wr_en   = 1'b1;
                            wr_addr = off_reg;
                            wr_data = {attr_reg, char_reg};
                        end
                        if (pr_scroll) begin
                            off_next     = BOTTOM_ROW;
                            col_next     = '0;
                            row_next     = ROW_MAX;
                            res_scr_next = 1'b1;
                            sweep_next   = ROW_STRIDE;
                            state_next   = ST_COPY;
                        end else begin
                            off_next   = ADDR_W'(pr_off);
                            col_next   = pr_col;
                            row_next   = pr_row;
                            state_next = ST_DONE;
                        end
                    end
                    MODE_CLEAR: begin
                        off_next   = '0;
                        col_next   = '0;
                        row_next   = '0;
                        sweep_next = '0;
                        state_next = ST_CLEAR;
                    end
                    MODE_SET_CURSOR, MODE_READ, MODE_WRITE: begin
                        sat_col_next = sat_col;
                        sat_row_next = sat_row;
                        inside_next  = col_ok && row_ok;
                        pos_next     = ADDR_W'(sat_row * COLUMNS) + ADDR_W'(sat_col);
                        state_next   = ST_ACCESS;
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end

            ST_ACCESS: begin
                state_next = ST_DONE;
                case (mode_reg)
                    MODE_SET_CURSOR: begin
                        off_next = pos_reg;
                        col_next = sat_col_reg;
                        row_next = sat_row_reg;
                    end
                    MODE_READ: begin
                        if (inside_reg) begin
                            rd_en      = 1'b1;
                            rd_addr    = pos_reg;
                            state_next = ST_READ_WAIT;
                        end
                    end
                    MODE_WRITE: begin
                        if (inside_reg) begin
                            wr_en   = 1'b1;
                            wr_addr = pos_reg;
                            wr_data = {attr_reg, char_reg};
                        end
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end

            ST_READ_WAIT: begin
                res_char_next = rd_data[7:0];
                res_attr_next = rd_data[15:8];
                state_next    = ST_DONE;
            end

            // Scroll copy: read cell i and write it one row up from the registered read data
            ST_COPY: begin
                rd_en          = 1'b1;
                rd_addr        = sweep_reg;
                pend_next      = 1'b1;
                pend_addr_next = sweep_reg - ROW_STRIDE;
                if (pend_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = pend_addr_reg;
                    wr_data = rd_data;
                end
                if (sweep_reg == LAST_CELL) begin
                    state_next = ST_COPY_END;
                end else begin
                    sweep_next = sweep_reg + ADDR_W'(1);
                end
            end

            ST_COPY_END: begin
                wr_en      = 1'b1;
                wr_addr    = pend_addr_reg;
                wr_data    = rd_data;
                sweep_next = BOTTOM_ROW;
                state_next = ST_FILL;
            end

            // Bottom row to spaces
            ST_FILL: begin
                wr_en = 1'b1;
                if (sweep_reg == LAST_CELL) begin
                    state_next = ST_DONE;
                end else begin
                    sweep_next = sweep_reg + ADDR_W'(1);
                end
            end

            ST_CLEAR: begin
                wr_en = 1'b1;
                if (sweep_reg == LAST_CELL) begin
                    state_next = ST_DONE;
                end else begin
                    sweep_next = sweep_reg + ADDR_W'(1);
                end
            end

            // Hand the result over once the output register is free
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    m_tdata_next[OUT_COL_LSB +: 7]  = 7'(col_reg);
                    m_tdata_next[OUT_ROW_LSB +: 5]  = 5'(row_reg);
                    m_tdata_next[OUT_CHAR_LSB +: 8] = res_char_reg;
                    m_tdata_next[OUT_ATTR_LSB +: 8] = res_attr_reg;
                    m_tdata_next[OUT_SCR_BIT]       = res_scr_reg;
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

endmodule : text_mode_console_writer

`default_nettype wire

// File: rtl/tmcw_cell_ram.sv
// Screen cell store: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module tmcw_cell_ram #(
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = 11
) (
    input  wire logic                        aclk,
    input  wire logic                        wr_en,
    input  wire logic [ADDR_W-1:0]           wr_addr,
    input  wire logic [tmcw_pkg::CELL_W-1:0] wr_data,
    input  wire logic                        rd_en,
    input  wire logic [ADDR_W-1:0]           rd_addr,
    output logic      [tmcw_pkg::CELL_W-1:0] rd_data
);
    import tmcw_pkg::*;

    logic [CELL_W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data valid the cycle after the address
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule : tmcw_cell_ram

`default_nettype wire

// File: rtl/tmcw_checker.sv
// Port-level checks for the text-mode console writer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module tmcw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata
);
    import tmcw_pkg::*;

    // One command at a time: ready drops right after an item is taken
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("command accepted while another is in progress");

    // A result is held until the receiver takes it
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn before it was taken");

    // After a scroll the cursor sits at the start of the bottom row
    a_scroll_cursor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[OUT_SCR_BIT] |->
            (m_tdata[OUT_COL_LSB +: 7] == 7'd0) &&
            (m_tdata[OUT_ROW_LSB +: 5] == 5'(ROWS - 1)))
        else $error("scroll left the cursor off the bottom row start");

    // Reported cursor column stays on the grid
    a_column_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (COLUMNS > 128) || (32'(m_tdata[OUT_COL_LSB +: 7]) < COLUMNS))
        else $error("cursor column beyond the last column");

endmodule : tmcw_checker

bind text_mode_console_writer tmcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tmcw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// File: tb/text_mode_console_writer_test.sv
// Self-checking testbench for the text-mode console writer: directed table, then random traffic.
`timescale 1ns / 1ps

module text_mode_console_writer_test;
    import tmcw_pkg::*;

    localparam int SCREEN_COLS = 80;
    localparam int SCREEN_ROWS = 25;
    localparam int CELLS       = SCREEN_COLS * SCREEN_ROWS;
    localparam int TAB_W       = TAB_STOP;

    // Modes the block leaves unused
    localparam logic [2:0] MODE_RESERVED_5 = 3'd5;
    localparam logic [2:0] MODE_RESERVED_6 = 3'd6;
    localparam logic [2:0] MODE_RESERVED_7 = 3'd7;

    localparam int DIRECTED_ROWS = 25;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 240;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 3000;
    localparam int TAIL_CYCLES   = 20;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] ch;
        logic [6:0] col;
        logic [4:0] row;
    } console_cmd_t;

    typedef struct packed {
        logic [6:0] cur_col;
        logic [4:0] cur_row;
        logic [7:0] rd_char;
        logic [7:0] rd_attr;
        logic       scrolled;
    } console_result_t;

    typedef struct packed {
        console_cmd_t    cmd;
        logic            fixed;
        console_result_t want;
    } directed_row_t;

    localparam console_result_t FROM_MODEL = '0;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // char_code[7:0], column[14:8], row[19:15]
    logic [2:0]  s_tuser;   // mode[2:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // cursor_column, cursor_row, read_char, read_attr, scrolled
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;

    // Console shadow: cursor, cell store and attribute
    int unsigned     cursor_pos;
    logic [15:0]     screen_model [0:CELLS-1];
    logic [7:0]      attr_model;
    console_result_t expected_results [$];
    int              error_count = 0;
    bit              long_hold_req = 1'b0;
    directed_row_t   directed_cmds [0:DIRECTED_ROWS-1];

    text_mode_console_writer #(
        .COLUMNS(SCREEN_COLS),
        .ROWS   (SCREEN_ROWS)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Apply one command to the shadow console and return its result
    function automatic console_result_t console_apply(input console_cmd_t cmd);
        console_result_t res;
        int unsigned col;
        int unsigned row;
        bit on_grid;
        res = '0;
        col = cmd.col;
        row = cmd.row;
        on_grid = (col < SCREEN_COLS) && (row < SCREEN_ROWS);
        case (cmd.mode)
            MODE_PRINT: begin
                if (cmd.ch == CH_NEWLINE)
                    cursor_pos += SCREEN_COLS - cursor_pos % SCREEN_COLS;
                else if (cmd.ch == CH_TAB)
                    cursor_pos += TAB_W - cursor_pos % TAB_W;
                else begin
                    screen_model[cursor_pos] = {attr_model, cmd.ch};
                    cursor_pos++;
                end
                // past the last cell: move rows up, blank the bottom row
                if (cursor_pos >= CELLS) begin
                    for (int i = 0; i < CELLS - SCREEN_COLS; i++)
                        screen_model[i] = screen_model[i + SCREEN_COLS];
                    for (int i = CELLS - SCREEN_COLS; i < CELLS; i++)
                        screen_model[i] = {attr_model, CH_SPACE};
                    cursor_pos = CELLS - SCREEN_COLS;
                    res.scrolled = 1'b1;
                end
            end
            MODE_SET_CURSOR: begin
                if (col >= SCREEN_COLS) col = SCREEN_COLS - 1;
                if (row >= SCREEN_ROWS) row = SCREEN_ROWS - 1;
                cursor_pos = row * SCREEN_COLS + col;
            end
            MODE_CLEAR: begin
                for (int i = 0; i < CELLS; i++)
                    screen_model[i] = {attr_model, CH_SPACE};
                cursor_pos = 0;
            end
            MODE_READ: begin
                if (on_grid)
                    {res.rd_attr, res.rd_char} = screen_model[row * SCREEN_COLS + col];
            end
            MODE_WRITE: begin
                if (on_grid)
                    screen_model[row * SCREEN_COLS + col] = {attr_model, cmd.ch};
            end
            default: ;
        endcase
        res.cur_col = 7'(cursor_pos % SCREEN_COLS);
        res.cur_row = 5'(cursor_pos / SCREEN_COLS);
        return res;
    endfunction

    // Idle length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(15, 60);
    endfunction

    // Random command over the whole field ranges, weighted towards valid positions
    function automatic console_cmd_t random_command();
        console_cmd_t cmd;
        int r;
        cmd.ch  = 8'($urandom_range(0, 255));
        cmd.col = 7'($urandom_range(0, 127));
        cmd.row = 5'($urandom_range(0, 31));
        r = $urandom_range(0, 99);
        if (r < 50) begin
            cmd.mode = MODE_PRINT;
            r = $urandom_range(0, 99);
            if (r < 12) cmd.ch = CH_NEWLINE;
            else if (r < 20) cmd.ch = CH_TAB;
        end else if (r < 62) begin
            cmd.mode = MODE_SET_CURSOR;
            // often near the bottom-right corner so prints scroll soon
            if ($urandom_range(0, 3) == 0) begin
                cmd.row = 5'(SCREEN_ROWS - 1);
                cmd.col = 7'($urandom_range(70, 127));
            end
        end else if (r < 64) begin
            cmd.mode = MODE_CLEAR;
        end else if (r < 94) begin
            cmd.mode = (r < 82) ? MODE_READ : MODE_WRITE;
            if ($urandom_range(0, 99) < 85) begin
                cmd.col = 7'($urandom_range(0, SCREEN_COLS - 1));
                cmd.row = 5'($urandom_range(0, SCREEN_ROWS - 1));
            end
        end else begin
            cmd.mode = 3'($urandom_range(MODE_RESERVED_5, MODE_RESERVED_7));
        end
        return cmd;
    endfunction

    // Mismatch logging
    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("%0t ns: %s got 0x%0h, want 0x%0h", $time, what, got, want);
    endtask

    // Offer one command item; valid stays high after acceptance until changed
    task automatic issue_command(input console_cmd_t cmd, input logic fixed,
                                 input console_result_t want, input int gap);
        console_result_t predicted;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd.mode;
        s_tdata  <= {4'd0, cmd.row, cmd.col, cmd.ch};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = console_apply(cmd);
        expected_results.push_back(fixed ? want : predicted);
    endtask

    // Stop offering and wait for every outstanding result
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    // Attribute write, only with the block idle
    task automatic write_attribute(input logic [7:0] value);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid  <= 1'b0;
        attr_model = value;
    endtask

    // Result checking against the oldest expectation
    always @(posedge aclk) begin : result_check
        console_result_t want;
        console_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.cur_col  = m_tdata[OUT_COL_LSB +: 7];
            got.cur_row  = m_tdata[OUT_ROW_LSB +: 5];
            got.rd_char  = m_tdata[OUT_CHAR_LSB +: 8];
            got.rd_attr  = m_tdata[OUT_ATTR_LSB +: 8];
            got.scrolled = m_tdata[OUT_SCR_BIT];
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result item", m_tdata, 0);
            end else begin
                want = expected_results.pop_front();
                if (got.cur_col != want.cur_col)
                    report_mismatch("cursor_column", got.cur_col, want.cur_col);
                if (got.cur_row != want.cur_row)
                    report_mismatch("cursor_row", got.cur_row, want.cur_row);
                if (got.rd_char != want.rd_char)
                    report_mismatch("read_char", got.rd_char, want.rd_char);
                if (got.rd_attr != want.rd_attr)
                    report_mismatch("read_attr", got.rd_attr, want.rd_attr);
                if (got.scrolled != want.scrolled)
                    report_mismatch("scrolled", got.scrolled, want.scrolled);
            end
        end
    end

    // Result side back-pressure, with steady stretches and requested long holds
    initial begin : result_drain
        int r;
        int hold;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (long_hold_req) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                long_hold_req = 1'b0;
            end else begin
                r = $urandom_range(0, 9);
                hold = pick_gap();
                if (r == 0) begin
                    m_tready <= 1'b1;
                    repeat ($urandom_range(100, 300)) @(posedge aclk);
                end else if (hold > 0) begin
                    m_tready <= 1'b0;
                    repeat (hold) @(posedge aclk);
                end else begin
                    m_tready <= 1'b1;
                    repeat ($urandom_range(1, 8)) @(posedge aclk);
                end
            end
        end
    end

    // Stimulus: directed table, then random phases at several attributes
    initial begin : stimulus
        console_cmd_t cmd;
        bit steady;
        int issued;
        int len;
        logic [7:0] attr_value;

        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= MODE_PRINT;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        aresetn   <= 1'b0;

        cursor_pos = 0;
        attr_model = ATTR_RESET;
        for (int i = 0; i < CELLS; i++) screen_model[i] = '0;

        // mode, char, column, row, typed-in flag, result (col, row, char, attr, scrolled)
        directed_cmds = '{
            '{'{MODE_READ,       8'h00,      7'd0,   5'd0},  1'b1,
              '{7'd0,  5'd0,  8'h00, 8'h00, 1'b0}},
            '{'{MODE_PRINT,      8'h41,      7'd0,   5'd0},  1'b1,
              '{7'd1,  5'd0,  8'h00, 8'h00, 1'b0}},
            '{'{MODE_READ,       8'h00,      7'd0,   5'd0},  1'b1,
              '{7'd1,  5'd0,  8'h41, 8'h07, 1'b0}},
            '{'{MODE_PRINT,      CH_TAB,     7'd0,   5'd0},  1'b1,
              '{7'd8,  5'd0,  8'h00, 8'h00, 1'b0}},
            '{'{MODE_PRINT,      CH_NEWLINE, 7'd0,   5'd0},  1'b1,
              '{7'd0,  5'd1,  8'h00, 8'h00, 1'b0}},
            '{'{MODE_PRINT,      8'h00,      7'd0,   5'd0},  1'b1,
              '{7'd1,  5'd1,  8'h00, 8'h00, 1'b0}},
            '{'{MODE_PRINT,      8'hFF,      7'd127, 5'd31}, 1'b0, FROM_MODEL},
            // out-of-range cursor saturates to the last cell
            '{'{MODE_SET_CURSOR, 8'h00,      7'd127, 5'd31}, 1'b1,
              '{7'd79, 5'd24, 8'h00, 8'h00, 1'b0}},
            '{'{MODE_PRINT,      8'h5A,      7'd0,   5'd0},  1'b1,
              '{7'd0,  5'd24, 8'h00, 8'h00, 1'b1}},
            '{'{MODE_READ,       8'h00,      7'd79,  5'd23}, 1'b1,
              '{7'd0,  5'd24, 8'h5A, 8'h07, 1'b0}},
            '{'{MODE_READ,       8'h00,      7'd1,   5'd0},  1'b1,
              '{7'd0,  5'd24, 8'hFF, 8'h07, 1'b0}},
            '{'{MODE_READ,       8'h00,      7'd5,   5'd24}, 1'b1,
              '{7'd0,  5'd24, 8'h20, 8'h07, 1'b0}},
            '{'{MODE_SET_CURSOR, 8'h00,      7'd79,  5'd24}, 1'b1,
              '{7'd79, 5'd24, 8'h00, 8'h00, 1'b0}},
            // tab and newline off the bottom row both scroll
            '{'{MODE_PRINT,      CH_TAB,     7'd0,   5'd0},  1'b1,
              '{7'd0,  5'd24, 8'h00, 8'h00, 1'b1}},
            '{'{MODE_PRINT,      CH_NEWLINE, 7'd0,   5'd0},  1'b1,
              '{7'd0,  5'd24, 8'h00, 8'h00, 1'b1}},
            // writes and reads off the grid and at the last cell
            '{'{MODE_WRITE,      8'hC3,      7'd127, 5'd31}, 1'b1,
              '{7'd0,  5'd24, 8'h00, 8'h00, 1'b0}},
            '{'{MODE_READ,       8'h00,      7'd80,  5'd0},  1'b1,
              '{7'd0,  5'd24, 8'h00, 8'h00, 1'b0}},
            '{'{MODE_WRITE,      8'hC3,      7'd79,  5'd24}, 1'b0, FROM_MODEL},
            '{'{MODE_READ,       8'h00,      7'd79,  5'd24}, 1'b1,
              '{7'd0,  5'd24, 8'hC3, 8'h07, 1'b0}},
            '{'{MODE_RESERVED_5, 8'hFF,      7'd127, 5'd31}, 1'b1,
              '{7'd0,  5'd24, 8'h00, 8'h00, 1'b0}},
            '{'{MODE_RESERVED_6, 8'hFF,      7'd127, 5'd31}, 1'b1,
              '{7'd0,  5'd24, 8'h00, 8'h00, 1'b0}},
            '{'{MODE_RESERVED_7, 8'h00,      7'd0,   5'd0},  1'b1,
              '{7'd0,  5'd24, 8'h00, 8'h00, 1'b0}},
            '{'{MODE_SET_CURSOR, 8'h00,      7'd80,  5'd0},  1'b1,
              '{7'd79, 5'd0,  8'h00, 8'h00, 1'b0}},
            '{'{MODE_CLEAR,      8'h00,      7'd0,   5'd0},  1'b1,
              '{7'd0,  5'd0,  8'h00, 8'h00, 1'b0}},
            '{'{MODE_READ,       8'h00,      7'd79,  5'd24}, 1'b1,
              '{7'd0,  5'd0,  8'h20, 8'h07, 1'b0}}
        };

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++)
            issue_command(directed_cmds[i].cmd, directed_cmds[i].fixed,
                          directed_cmds[i].want, pick_gap());

        for (int phase = 0; phase < PHASES; phase++) begin
            attr_value = (phase == 0) ? 8'h00 :
                         (phase == 1) ? 8'hFF : 8'($urandom_range(0, 255));
            write_attribute(attr_value);
            if (phase == 1 || phase == 5) long_hold_req = 1'b1;
            issued = 0;
            while (issued < PHASE_ITEMS) begin
                steady = ($urandom_range(0, 9) == 0);
                if ($urandom_range(0, 99) < 30) begin
                    // a line of text, sometimes placed first, ending in a newline
                    if ($urandom_range(0, 1) == 1) begin
                        cmd      = random_command();
                        cmd.mode = MODE_SET_CURSOR;
                        issue_command(cmd, 1'b0, FROM_MODEL, steady ? 0 : pick_gap());
                        issued++;
                    end
                    len = $urandom_range(4, 30);
                    for (int k = 0; k < len; k++) begin
                        cmd      = random_command();
                        cmd.mode = MODE_PRINT;
                        cmd.ch   = (k == len - 1) ? CH_NEWLINE : 8'($urandom_range(8'h20, 8'h7E));
                        issue_command(cmd, 1'b0, FROM_MODEL, steady ? 0 : pick_gap());
                    end
                    issued += len;
                end else begin
                    issue_command(random_command(), 1'b0, FROM_MODEL,
                                  steady ? 0 : pick_gap());
                    issued++;
                end
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("text_mode_console_writer verification clean");
        else
            $display("text_mode_console_writer verification failed");
        $finish;
    end

    // Run limit
    initial begin : run_limit
        #200_000_000;
        $display("text_mode_console_writer verification failed");
        $finish;
    end

endmodule
